FILE: rtl/esi_pkg.sv
// Package for the error-state injection block: field widths, sequencer states
// and the product schedule of the quaternion update. No dependencies.
package esi_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int INDEX_WIDTH = 4;

  localparam logic [INDEX_WIDTH-1:0] IDX_QUAT_W = 4'd6;
  localparam logic [INDEX_WIDTH-1:0] IDX_QUAT_X = 4'd7;
  localparam logic [INDEX_WIDTH-1:0] IDX_QUAT_Y = 4'd8;
  localparam logic [INDEX_WIDTH-1:0] IDX_QUAT_Z = 4'd9;

  typedef enum logic [3:0] {
    QS_IDLE,
    QS_INIT,
    QS_MUL,
    QS_ACC,
    QS_MAG,
    QS_NORM,
    QS_SQ,
    QS_SQACC,
    QS_SQRT,
    QS_DSET,
    QS_DSTEP,
    QS_EMIT
  } quat_state_t;

  typedef struct packed {
    logic [1:0] comp;
    logic [1:0] phi_sel;
    logic [1:0] nom_sel;
    logic       sub;
  } mul_sel_t;

  typedef struct packed {
    logic                   busy;
    logic                   res_valid;
    logic [INDEX_WIDTH-1:0] res_index;
    logic [WORD_WIDTH-1:0]  res_value;
    logic                   res_zero;
    logic                   res_last;
  } quat_status_t;

  // Cross terms of the Hamilton product dq*q that involve the vector part of dq.
  function automatic mul_sel_t mul_sched(input logic [3:0] step);
    mul_sel_t s;
    s = '0;
    case (step)
      4'd0:  s = '{comp: 2'd0, phi_sel: 2'd0, nom_sel: 2'd1, sub: 1'b1};
      4'd1:  s = '{comp: 2'd0, phi_sel: 2'd1, nom_sel: 2'd2, sub: 1'b1};
      4'd2:  s = '{comp: 2'd0, phi_sel: 2'd2, nom_sel: 2'd3, sub: 1'b1};
      4'd3:  s = '{comp: 2'd1, phi_sel: 2'd0, nom_sel: 2'd0, sub: 1'b0};
      4'd4:  s = '{comp: 2'd1, phi_sel: 2'd1, nom_sel: 2'd3, sub: 1'b0};
      4'd5:  s = '{comp: 2'd1, phi_sel: 2'd2, nom_sel: 2'd2, sub: 1'b1};
      4'd6:  s = '{comp: 2'd2, phi_sel: 2'd0, nom_sel: 2'd3, sub: 1'b1};
      4'd7:  s = '{comp: 2'd2, phi_sel: 2'd1, nom_sel: 2'd0, sub: 1'b0};
      4'd8:  s = '{comp: 2'd2, phi_sel: 2'd2, nom_sel: 2'd1, sub: 1'b0};
      4'd9:  s = '{comp: 2'd3, phi_sel: 2'd0, nom_sel: 2'd2, sub: 1'b0};
      4'd10: s = '{comp: 2'd3, phi_sel: 2'd1, nom_sel: 2'd1, sub: 1'b1};
      4'd11: s = '{comp: 2'd3, phi_sel: 2'd2, nom_sel: 2'd0, sub: 1'b0};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/esi_in_if.sv
// Input channel of the error-state injection block: one state element per transfer.
// Depends on esi_pkg.
interface esi_in_if;
  logic                              valid;
  logic                              ready;
  logic [esi_pkg::INDEX_WIDTH-1:0]   element_index;
  logic signed [esi_pkg::WORD_WIDTH-1:0] nominal_value;
  logic signed [esi_pkg::WORD_WIDTH-1:0] error_value;

  modport source (output valid, element_index, nominal_value, error_value, input ready);
  modport sink (input valid, element_index, nominal_value, error_value, output ready);
endinterface

FILE: rtl/esi_out_if.sv
// Output channel of the error-state injection block: one corrected element per transfer.
// Depends on esi_pkg.
interface esi_out_if;
  logic                              valid;
  logic                              ready;
  logic [esi_pkg::INDEX_WIDTH-1:0]   result_index;
  logic signed [esi_pkg::WORD_WIDTH-1:0] corrected_value;
  logic                              zero_norm;
  logic                              last_of_run;

  modport source (output valid, result_index, corrected_value, zero_norm, last_of_run,
                  input ready);
  modport sink (input valid, result_index, corrected_value, zero_norm, last_of_run,
                output ready);
endinterface

FILE: rtl/esi_quat_unit.sv
// Quaternion update: Hamilton product, normalizing shift, square root and division,
// all on one shared multiplier. Depends on esi_pkg.
module esi_quat_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           res_ready,
  input  logic [esi_pkg::WORD_WIDTH-1:0] nom [4],
  input  logic [esi_pkg::WORD_WIDTH-1:0] phi [3],
  output esi_pkg::quat_status_t          status
);
  import esi_pkg::*;

  quat_state_t state, state_next;
  logic [4:0]  cnt;
  logic [1:0]  c;
  logic [63:0] r [4];
  logic [3:0]  neg;
  logic        zero;
  logic signed [63:0] prod;
  logic [63:0] sum, v, res, bitr;
  logic [30:0] rem, dlow, q;
  logic [31:0] qres [4];

  mul_sel_t    sel;
  logic signed [31:0] op_a, op_b;
  logic [63:0] orv, trial;
  logic        sq_ge;
  logic [30:0] norm;
  logic [60:0] dword;
  logic [31:0] rem2, rem_sub;
  logic        div_ge;
  logic [30:0] q_next;
  logic [63:0] prod_q;

  assign sel = mul_sched(cnt[3:0]);
  assign op_a = (state == QS_MUL) ? $signed(phi[sel.phi_sel]) : $signed({2'b0, r[c][29:0]});
  assign op_b = (state == QS_MUL) ? $signed(nom[sel.nom_sel]) : $signed({2'b0, r[c][29:0]});
  assign orv = r[0] | r[1] | r[2] | r[3];
  assign trial = res + bitr;
  assign sq_ge = v >= trial;
  assign norm = (res[30:0] == '0) ? 31'd1 : res[30:0];
  assign dword = {1'b0, r[c][29:0], 30'b0} + {31'b0, norm[30:1]};
  assign rem2 = {rem, dlow[30]};
  assign div_ge = rem2 >= {1'b0, norm};
  assign rem_sub = rem2 - {1'b0, norm};
  assign q_next = {q[29:0], div_ge};
  assign prod_q = 64'(prod >>> 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= QS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      QS_IDLE:  if (start) state_next = QS_INIT;
      QS_INIT:  state_next = QS_MUL;
      QS_MUL:   state_next = QS_ACC;
      QS_ACC:   state_next = (cnt == 5'd11) ? QS_MAG : QS_MUL;
      QS_MAG:   state_next = QS_NORM;
      QS_NORM: begin
        if (orv == '0) state_next = QS_EMIT;
        else if (orv[63:30] == '0 && orv[29]) state_next = QS_SQ;
      end
      QS_SQ:    state_next = QS_SQACC;
      QS_SQACC: state_next = (c == 2'd3) ? QS_SQRT : QS_SQ;
      QS_SQRT:  if (cnt == 5'd31) state_next = QS_DSET;
      QS_DSET:  state_next = QS_DSTEP;
      QS_DSTEP: begin
        if (cnt == 5'd30) state_next = (c == 2'd3) ? QS_EMIT : QS_DSET;
      end
      QS_EMIT:  if (res_ready && c == 2'd3) state_next = QS_IDLE;
      default:  state_next = QS_IDLE;
    endcase
  end

  always_comb begin
    status.busy = (state != QS_IDLE);
    status.res_valid = (state == QS_EMIT);
    status.res_index = IDX_QUAT_W + {2'b0, c};
    status.res_value = zero ? '0 : qres[c];
    status.res_zero = zero;
    status.res_last = (c == 2'd3);
  end

  always_ff @(posedge clk) begin
    case (state)
      QS_INIT: begin
        for (int k = 0; k < 4; k++) begin
          r[k] <= {{3{nom[k][31]}}, nom[k], 29'b0};
        end
        cnt <= '0;
        zero <= 1'b0;
      end
      QS_MUL: prod <= op_a * op_b;
      QS_ACC: begin
        r[sel.comp] <= sel.sub ? r[sel.comp] - prod_q : r[sel.comp] + prod_q;
        cnt <= cnt + 5'd1;
      end
      QS_MAG: begin
        for (int k = 0; k < 4; k++) begin
          neg[k] <= r[k][63];
          r[k] <= r[k][63] ? (64'd0 - r[k]) : r[k];
        end
        sum <= '0;
        c <= '0;
      end
      QS_NORM: begin
        if (orv == '0) begin
          zero <= 1'b1;
        end else if (orv[63:30] != '0) begin
          for (int k = 0; k < 4; k++) r[k] <= r[k] >> 1;
        end else if (!orv[29]) begin
          for (int k = 0; k < 4; k++) r[k] <= r[k] << 1;
        end
      end
      QS_SQ: prod <= op_a * op_b;
      QS_SQACC: begin
        sum <= sum + 64'(prod);
        v <= sum + 64'(prod);
        res <= '0;
        bitr <= 64'd1 << 62;
        cnt <= '0;
        c <= c + 2'd1;
      end
      QS_SQRT: begin
        if (sq_ge) begin
          v <= v - trial;
          res <= (res >> 1) + bitr;
        end else begin
          res <= res >> 1;
        end
        bitr <= bitr >> 2;
        cnt <= cnt + 5'd1;
      end
      QS_DSET: begin
        rem <= {1'b0, dword[60:31]};
        dlow <= dword[30:0];
        q <= '0;
        cnt <= '0;
      end
      QS_DSTEP: begin
        rem <= div_ge ? rem_sub[30:0] : rem2[30:0];
        dlow <= {dlow[29:0], 1'b0};
        q <= q_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          qres[c] <= neg[c] ? (32'd0 - {1'b0, q_next}) : {1'b0, q_next};
          c <= c + 2'd1;
        end
      end
      QS_EMIT: if (res_ready) c <= c + 2'd1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/error_state_injection_top.sv
// Top level of the error-state injection block: input buffering, saturating adds,
// output register and the quaternion unit. Depends on esi_pkg, esi_in_if, esi_out_if
// and esi_quat_unit.
//
// Position, velocity and bias elements give their corrected value in the cycle after
// the transfer, from the output register. Quaternion elements w, x and y are only
// stored; the z element starts the quaternion update on the shared multiplier:
// 12 multiplies, a normalizing shift of one bit per cycle, four squares, a 32-step
// square root and four divisions. When the product is all zero, the squares, root
// and divisions are skipped and zero results with zero_norm set are given. The four
// components then leave in w, x, y, z order on consecutive cycles unless the
// receiver stalls. No input is taken while that update runs.
module error_state_injection_top (
  input logic      clk,
  input logic      rst,
  esi_in_if.sink   item,
  esi_out_if.source result
);
  import esi_pkg::*;

  logic [WORD_WIDTH-1:0] nom [4];
  logic [WORD_WIDTH-1:0] phi [3];
  quat_status_t          ust;
  logic                  slot_free, accept, is_quat, start, res_ready;
  logic [WORD_WIDTH:0]   sum_w;
  logic [WORD_WIDTH-1:0] sat;

  logic                   o_valid;
  logic [INDEX_WIDTH-1:0] o_index;
  logic [WORD_WIDTH-1:0]  o_value;
  logic                   o_zero, o_last;

  assign slot_free = !o_valid || result.ready;
  assign item.ready = !ust.busy && slot_free;
  assign accept = item.valid && item.ready;
  assign is_quat = (item.element_index >= IDX_QUAT_W) && (item.element_index <= IDX_QUAT_Z);
  assign start = accept && (item.element_index == IDX_QUAT_Z);
  assign res_ready = slot_free && ust.res_valid;

  assign sum_w = {item.nominal_value[WORD_WIDTH-1], item.nominal_value}
               + {item.error_value[WORD_WIDTH-1], item.error_value};
  assign sat = (sum_w[WORD_WIDTH] != sum_w[WORD_WIDTH-1])
             ? {sum_w[WORD_WIDTH], {(WORD_WIDTH-1){!sum_w[WORD_WIDTH]}}}
             : sum_w[WORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) nom[k] <= '0;
      for (int k = 0; k < 3; k++) phi[k] <= '0;
    end else if (accept && is_quat) begin
      nom[2'(item.element_index - IDX_QUAT_W)] <= item.nominal_value;
      if (item.element_index != IDX_QUAT_W) begin
        phi[2'(item.element_index - IDX_QUAT_X)] <= item.error_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (slot_free) begin
      o_valid <= (accept && !is_quat) || ust.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (accept && !is_quat) begin
        o_index <= item.element_index;
        o_value <= sat;
        o_zero <= 1'b0;
        o_last <= 1'b1;
      end else if (ust.res_valid) begin
        o_index <= ust.res_index;
        o_value <= ust.res_value;
        o_zero <= ust.res_zero;
        o_last <= ust.res_last;
      end
    end
  end

  assign result.valid = o_valid;
  assign result.result_index = o_index;
  assign result.corrected_value = o_value;
  assign result.zero_norm = o_zero;
  assign result.last_of_run = o_last;

  esi_quat_unit u_quat (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .res_ready (res_ready),
    .nom       (nom),
    .phi       (phi),
    .status    (ust)
  );

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> ust.busy) else $error("quaternion unit did not start");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    ust.busy |-> !item.ready) else $error("input taken during quaternion update");
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_zero) |-> (o_value == '0)) else $error("zero norm with nonzero value");
  a_trans_last: assert property (@(posedge clk) disable iff (rst)
    (o_valid && (o_index < IDX_QUAT_W || o_index > IDX_QUAT_Z)) |-> (o_last && !o_zero))
    else $error("translational result flags wrong");
`endif

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for error_state_injection_top: drives directed and random state
// elements, predicts the saturated sums and the normalized quaternion, checks results.
// Depends on esi_pkg, esi_in_if, esi_out_if and error_state_injection_top.
module tb_top;
  import esi_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [3:0] IDX_POS_X = 4'd0;
  localparam logic [3:0] IDX_GYRO_Z = 4'd15;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] nom;
    logic signed [31:0] err;
    bit                 wait_empty;
  } element_t;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] value;
    logic        zero;
    logic        last;
  } corrected_t;

  logic clk;
  logic rst;
  esi_in_if  item();
  esi_out_if result();

  error_state_injection_top dut (.clk(clk), .rst(rst), .item(item), .result(result));

  element_t   elements_to_send[$];
  corrected_t corrected_due[$];
  logic signed [31:0] nom_quat[4];
  logic signed [31:0] phi_store[3];
  logic elem_took;
  logic res_took;
  int   send_wait;
  int   recv_wait;
  int   recv_draw;
  int   long_hold;
  bit   long_done;
  bit   send_burst;
  int   results_seen;
  int   cycles;
  bit   failed;

  function automatic longint floor4(longint x);
    return x >>> 2;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic rotate_and_queue();
    longint a[4];
    longint q[4];
    longint r[4];
    longint unsigned mag[4];
    longint unsigned maxm;
    longint unsigned sum;
    longint unsigned norm;
    longint unsigned v;
    bit neg[4];
    bit zero;
    corrected_t c;
    a[0] = 64'sd2147483648;
    for (int i = 0; i < 3; i++) a[i+1] = phi_store[i];
    for (int i = 0; i < 4; i++) q[i] = nom_quat[i];
    r[0] = floor4(a[0]*q[0]) - floor4(a[1]*q[1]) - floor4(a[2]*q[2]) - floor4(a[3]*q[3]);
    r[1] = floor4(a[0]*q[1]) + floor4(a[1]*q[0]) + floor4(a[2]*q[3]) - floor4(a[3]*q[2]);
    r[2] = floor4(a[0]*q[2]) - floor4(a[1]*q[3]) + floor4(a[2]*q[0]) + floor4(a[3]*q[1]);
    r[3] = floor4(a[0]*q[3]) + floor4(a[1]*q[2]) - floor4(a[2]*q[1]) + floor4(a[3]*q[0]);
    maxm = 0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = r[i] < 0;
      mag[i] = neg[i] ? -r[i] : r[i];
      if (mag[i] > maxm) maxm = mag[i];
    end
    zero = (maxm == 0);
    if (!zero) begin
      while (maxm >= (64'd1 << 30)) begin
        maxm = maxm >> 1;
        for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
      end
      while (maxm < (64'd1 << 29)) begin
        maxm = maxm << 1;
        for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
      end
      for (int i = 0; i < 4; i++) sum = sum + mag[i] * mag[i];
      norm = root64(sum);
      if (norm == 0) norm = 1;
      for (int i = 0; i < 4; i++) mag[i] = ((mag[i] << 30) + (norm >> 1)) / norm;
    end
    for (int i = 0; i < 4; i++) begin
      v = zero ? 0 : mag[i];
      if (neg[i]) v = -v;
      c.idx = IDX_QUAT_W + 4'(i);
      c.value = v[31:0];
      c.zero = zero;
      c.last = (i == 3);
      corrected_due.push_back(c);
    end
  endtask

  task automatic inject_element(logic [3:0] idx, logic signed [31:0] nom,
                                logic signed [31:0] err);
    longint s;
    corrected_t c;
    if (idx >= IDX_QUAT_W && idx <= IDX_QUAT_Z) begin
      nom_quat[idx - IDX_QUAT_W] = nom;
      if (idx >= IDX_QUAT_X) phi_store[idx - IDX_QUAT_X] = err;
      if (idx == IDX_QUAT_Z) rotate_and_queue();
    end else begin
      s = longint'(nom) + longint'(err);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      c.idx = idx;
      c.value = s[31:0];
      c.zero = 1'b0;
      c.last = 1'b1;
      corrected_due.push_back(c);
    end
  endtask

  task automatic add_element(logic [3:0] idx, logic signed [31:0] nom, logic signed [31:0] err,
                             bit wait_empty = 0);
    element_t e;
    e.idx = idx;
    e.nom = nom;
    e.err = err;
    e.wait_empty = wait_empty;
    elements_to_send.push_back(e);
  endtask

  task automatic add_quat(logic signed [31:0] w, logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] z, logic signed [31:0] p0,
                          logic signed [31:0] p1, logic signed [31:0] p2);
    add_element(IDX_QUAT_W, w, $urandom());
    add_element(IDX_QUAT_X, x, p0);
    add_element(IDX_QUAT_Y, y, p1);
    add_element(IDX_QUAT_Z, z, p2);
  endtask

  function automatic logic signed [31:0] unit_part();
    return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
  endfunction

  function automatic logic signed [31:0] small_phi();
    return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  task automatic add_state_run();
    bit wild;
    wild = ($urandom_range(0, 9) < 3);
    for (int i = 0; i < 6; i++) add_element(4'(i), $urandom(), wild ? $urandom() : small_phi());
    if (wild) add_quat($urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom());
    else add_quat(unit_part(), unit_part(), unit_part(), unit_part(),
                  small_phi(), small_phi(), small_phi());
    for (int i = 10; i < 16; i++)
      add_element(4'(i), $urandom(), wild ? $urandom() : small_phi());
  endtask

  initial begin
    clk = 0;
    rst = 1;
    item.valid = 0;
    item.element_index = '0;
    item.nominal_value = '0;
    item.error_value = '0;
    result.ready = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      elem_took <= 0;
      res_took <= 0;
      results_seen <= 0;
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("error_state_injection_top verification failed");
        $finish;
      end
      elem_took <= item.valid && item.ready;
      res_took <= result.valid && result.ready;
      if (item.valid && item.ready)
        inject_element(item.element_index, item.nominal_value, item.error_value);
      if (result.valid && result.ready) begin
        results_seen <= results_seen + 1;
        if (corrected_due.size() == 0) begin
          $display("%0t: unexpected result index %0d value %h", $time,
                   result.result_index, result.corrected_value);
          failed = 1;
        end else begin
          if (result.result_index !== corrected_due[0].idx ||
              result.corrected_value !== corrected_due[0].value ||
              result.zero_norm !== corrected_due[0].zero ||
              result.last_of_run !== corrected_due[0].last) begin
            $display("%0t: expected idx %0d value %h zero %b last %b, got %0d %h %b %b",
                     $time, corrected_due[0].idx, corrected_due[0].value,
                     corrected_due[0].zero, corrected_due[0].last, result.result_index,
                     result.corrected_value, result.zero_norm, result.last_of_run);
            failed = 1;
          end
          void'(corrected_due.pop_front());
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      item.valid <= 0;
      send_wait <= 0;
      send_burst <= 0;
    end else if (!item.valid || elem_took) begin
      if ($urandom_range(0, 19) == 0) send_burst <= ~send_burst;
      if (send_wait > 0) begin
        item.valid <= 0;
        send_wait <= send_wait - 1;
      end else if (elements_to_send.size() > 0 &&
                   (!elements_to_send[0].wait_empty || corrected_due.size() == 0)) begin
        item.valid <= 1;
        item.element_index <= elements_to_send[0].idx;
        item.nominal_value <= elements_to_send[0].nom;
        item.error_value <= elements_to_send[0].err;
        send_wait <= send_burst ? 0 : $urandom_range(0, 9);
        void'(elements_to_send.pop_front());
      end else begin
        item.valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 0;
      recv_wait <= 0;
      long_hold <= 0;
      long_done <= 0;
    end else if (long_hold > 0) begin
      result.ready <= (long_hold == 1);
      long_hold <= long_hold - 1;
    end else if (res_took && results_seen >= 60 && !long_done) begin
      result.ready <= 0;
      long_hold <= 400;
      long_done <= 1;
    end else if (res_took) begin
      recv_draw = $urandom_range(0, 9);
      result.ready <= (recv_draw == 0);
      recv_wait <= (recv_draw == 0) ? 0 : recv_draw - 1;
    end else if (recv_wait > 0) begin
      result.ready <= 0;
      recv_wait <= recv_wait - 1;
    end else begin
      result.ready <= 1;
    end
  end

  initial begin
    failed = 0;
    for (int i = 0; i < 4; i++) nom_quat[i] = '0;
    for (int i = 0; i < 3; i++) phi_store[i] = '0;
    // Directed part: saturation at both ends, a lone z element, special quaternions.
    add_element(IDX_POS_X, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_element(4'd1, 32'sh8000_0000, 32'sh8000_0000);
    add_element(4'd2, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_element(4'd3, 32'sh0001_0000, -32'sh0000_8000);
    add_element(IDX_QUAT_Z, 32'sh0, 32'sh0);
    add_quat(32'sh4000_0000, 0, 0, 0, 0, 0, 0);
    add_quat(0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678);
    add_quat(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_quat(0, 0, 0, 1, 0, 0, 0);
    add_element(4'd10, 32'shFFFF_FFFF, 32'sh0000_0001, 1);
    add_element(IDX_GYRO_Z, 32'sh8000_0000, 32'shFFFF_FFFF);
    for (int n = 0; n < 22; n++) begin
      if (n == 9) add_element(IDX_POS_X, $urandom(), $urandom(), 1);
      if ($urandom_range(0, 4) == 0)
        for (int k = 0; k < 5; k++)
          add_element(4'($urandom_range(0, 15)), $urandom(), $urandom());
      else
        add_state_run();
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    wait (elements_to_send.size() == 0 && corrected_due.size() == 0);
    repeat (300) @(posedge clk);
    if (!failed && corrected_due.size() == 0) begin
      $display("error_state_injection_top verification clean");
    end else begin
      $display("error_state_injection_top verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/esi_pkg.sv
rtl/esi_in_if.sv
rtl/esi_out_if.sv
rtl/esi_quat_unit.sv
rtl/error_state_injection_top.sv
test/tb_top.sv
